/* sv/dmp_pkg.sv */
// Types and constants shared by the message parser's front end, queue and back end.
// Depends on nothing; every other file refers to it by scoped names.
package dmp_pkg;

   typedef enum logic [1:0] {
      REC_HEADER = 2'd0,
      REC_AVP    = 2'd1,
      REC_ACCEPT = 2'd2,
      REC_REJECT = 2'd3
   } rec_kind_type;

   typedef enum logic [2:0] {
      ERR_NONE         = 3'd0,
      ERR_UNDER_HEADER = 3'd1,
      ERR_BUFFER_SHORT = 3'd2,
      ERR_AVP_OVERRUN  = 3'd3,
      ERR_AVP_SHORT    = 3'd4
   } err_kind_type;

   typedef enum logic [1:0] {
      PH_HEADER = 2'd0,
      PH_WALK   = 2'd1,
      PH_DONE   = 2'd2,
      PH_ERROR  = 2'd3
   } phase_type;

   localparam logic [23:0] MAX_POS       = 24'hFFFFFF;
   localparam logic [23:0] HDR_LEN_FIRST = 24'd1;
   localparam logic [23:0] HDR_LEN_LAST  = 24'd3;
   localparam logic [23:0] HDR_CMD_FLAGS = 24'd4;
   localparam logic [23:0] HDR_CMD_LAST  = 24'd7;
   localparam logic [23:0] HDR_IDS_FIRST = 24'd8;
   localparam logic [23:0] HDR_IDS_LAST  = 24'd15;
   localparam logic [23:0] HDR_END_FIRST = 24'd16;
   localparam logic [23:0] HDR_END_IDX   = 24'd19;
   localparam logic [23:0] HDR_SIZE      = 24'd20;
   localparam logic [3:0]  AVP_HDR_SHORT = 4'd8;
   localparam logic [3:0]  AVP_HDR_LONG  = 4'd12;
   localparam logic [7:0]  AVP_LIMIT_RESET = 8'd50;

   localparam logic [23:0] CMD_CAPABILITIES = 24'd257;
   localparam logic [31:0] AVP_ORIGIN_HOST  = 32'd264;
   localparam logic [31:0] AVP_ORIGIN_REALM = 32'd296;
   localparam logic [31:0] AVP_HOST_ADDRESS = 32'd257;
   localparam logic [31:0] AVP_VENDOR_ID    = 32'd266;
   localparam logic [31:0] AVP_PRODUCT_NAME = 32'd269;
   localparam logic [4:0]  MAND_ALL         = 5'h1F;

   typedef struct packed {
      rec_kind_type record_kind;
      logic [31:0]  code;
      logic [7:0]   flags;
      logic [23:0]  length;
      logic [31:0]  vendor_or_app;
      logic [31:0]  hop_id;
      logic [31:0]  end_id;
      logic [23:0]  data_offset;
      logic [23:0]  data_length;
      logic [7:0]   avp_total;
      logic         cer_valid;
      err_kind_type error_kind;
   } record_type;

   // One queue entry: what a single byte produced, at most one record plus a final verdict.
   typedef struct packed {
      logic       has_rec;
      record_type rec;
      logic       has_final;
      record_type fin;
   } entry_type;

endpackage

/* sv/dmp_front.sv */
// Parser front end: assembles the header, walks AVPs one byte per accepted cycle.
// Depends on dmp_pkg; produces one queue entry for each byte that yields records.
module dmp_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                accept,
   input  logic [7:0]          data_byte,
   input  logic                last_byte,
   input  logic [7:0]          avp_limit,
   output logic                push,
   output dmp_pkg::entry_type  entry
);

   typedef struct packed {
      dmp_pkg::phase_type    phase;
      logic [23:0]           start;
      dmp_pkg::err_kind_type err;
   } begin_type;

   dmp_pkg::phase_type    phase_ff, phase_in;
   dmp_pkg::err_kind_type err_ff, err_in;
   logic [23:0] pos_ff, pos_in;
   logic [23:0] ml_ff, ml_in;
   logic [31:0] cmd_ff, cmd_in;
   logic [31:0] app_ff, app_in;
   logic [31:0] hop_ff, hop_in;
   logic [31:0] end_ff, end_in;
   logic [23:0] start_ff, start_in;
   logic [63:0] asm_ff, asm_in;
   logic [31:0] vend_ff, vend_in;
   logic [7:0]  count_ff, count_in;
   logic [4:0]  mand_ff, mand_in;

   logic [23:0] new_pos;
   logic [23:0] off;
   logic        do_finish;
   logic [3:0]  hsz;
   logic [23:0] avp_len;
   logic [25:0] next_avp;
   begin_type   bgn;
   dmp_pkg::err_kind_type fin_err;

   function automatic begin_type begin_avp(input logic [25:0] pos, input logic [23:0] mlen,
                                           input logic [7:0] cnt, input logic [7:0] lim);
      begin_type r;
      r.phase = dmp_pkg::PH_WALK;
      r.start = pos[23:0];
      r.err   = dmp_pkg::ERR_NONE;
      if ({2'b00, mlen} <= pos || cnt >= lim) begin
         r.phase = dmp_pkg::PH_DONE;
      end else if ({1'b0, pos} + 27'd8 > {3'b000, mlen}) begin
         r.phase = dmp_pkg::PH_ERROR;
         r.err   = dmp_pkg::ERR_AVP_OVERRUN;
      end
      return r;
   endfunction

   function automatic logic [4:0] mandatory_bit(input logic [31:0] avp_code);
      logic [4:0] m;
      case (avp_code)
         dmp_pkg::AVP_ORIGIN_HOST:  m = 5'b00001;
         dmp_pkg::AVP_ORIGIN_REALM: m = 5'b00010;
         dmp_pkg::AVP_HOST_ADDRESS: m = 5'b00100;
         dmp_pkg::AVP_VENDOR_ID:    m = 5'b01000;
         dmp_pkg::AVP_PRODUCT_NAME: m = 5'b10000;
         default:                   m = 5'b00000;
      endcase
      return m;
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= dmp_pkg::PH_HEADER;
         err_ff   <= dmp_pkg::ERR_NONE;
         pos_ff   <= '0;
         ml_ff    <= '0;
         cmd_ff   <= '0;
         app_ff   <= '0;
         hop_ff   <= '0;
         end_ff   <= '0;
         start_ff <= dmp_pkg::HDR_SIZE;
         asm_ff   <= '0;
         vend_ff  <= '0;
         count_ff <= '0;
         mand_ff  <= '0;
      end else begin
         phase_ff <= phase_in;
         err_ff   <= err_in;
         pos_ff   <= pos_in;
         ml_ff    <= ml_in;
         cmd_ff   <= cmd_in;
         app_ff   <= app_in;
         hop_ff   <= hop_in;
         end_ff   <= end_in;
         start_ff <= start_in;
         asm_ff   <= asm_in;
         vend_ff  <= vend_in;
         count_ff <= count_in;
         mand_ff  <= mand_in;
      end
   end

   always_comb begin
      phase_in = phase_ff;
      err_in   = err_ff;
      pos_in   = pos_ff;
      ml_in    = ml_ff;
      cmd_in   = cmd_ff;
      app_in   = app_ff;
      hop_in   = hop_ff;
      end_in   = end_ff;
      start_in = start_ff;
      asm_in   = asm_ff;
      vend_in  = vend_ff;
      count_in = count_ff;
      mand_in  = mand_ff;
      entry    = '0;
      do_finish = 1'b0;
      hsz      = dmp_pkg::AVP_HDR_SHORT;
      avp_len  = '0;
      next_avp = '0;
      bgn      = '0;
      fin_err  = dmp_pkg::ERR_NONE;
      off      = pos_ff - start_ff;
      new_pos  = (pos_ff == dmp_pkg::MAX_POS) ? pos_ff : pos_ff + 24'd1;

      if (accept) begin
         pos_in = new_pos;
         unique case (phase_ff)
            dmp_pkg::PH_HEADER: begin
               if (pos_ff >= dmp_pkg::HDR_LEN_FIRST && pos_ff <= dmp_pkg::HDR_LEN_LAST) begin
                  ml_in = {ml_ff[15:0], data_byte};
               end else if (pos_ff == dmp_pkg::HDR_CMD_FLAGS) begin
                  cmd_in = {data_byte, cmd_ff[23:0]};
               end else if (pos_ff > dmp_pkg::HDR_CMD_FLAGS && pos_ff <= dmp_pkg::HDR_CMD_LAST) begin
                  cmd_in = {cmd_ff[31:24], cmd_ff[15:0], data_byte};
               end else if (pos_ff >= dmp_pkg::HDR_IDS_FIRST && pos_ff <= dmp_pkg::HDR_IDS_LAST) begin
                  {app_in, hop_in} = {app_ff[23:0], hop_ff, data_byte};
               end else if (pos_ff >= dmp_pkg::HDR_END_FIRST && pos_ff <= dmp_pkg::HDR_END_IDX) begin
                  end_in = {end_ff[23:0], data_byte};
               end
               if (pos_ff == dmp_pkg::HDR_END_IDX) begin
                  entry.has_rec           = 1'b1;
                  entry.rec.record_kind   = dmp_pkg::REC_HEADER;
                  entry.rec.code          = {8'd0, cmd_in[23:0]};
                  entry.rec.flags         = cmd_in[31:24];
                  entry.rec.length        = ml_in;
                  entry.rec.vendor_or_app = app_in;
                  entry.rec.hop_id        = hop_in;
                  entry.rec.end_id        = end_in;
                  bgn = begin_avp({2'b00, dmp_pkg::HDR_SIZE}, ml_in, count_ff, avp_limit);
                  phase_in = bgn.phase;
                  err_in   = bgn.err;
                  if (bgn.phase == dmp_pkg::PH_WALK) begin
                     start_in = bgn.start;
                     asm_in   = '0;
                     vend_in  = '0;
                  end
               end
            end
            dmp_pkg::PH_WALK: begin
               if (pos_ff >= start_ff) begin
                  if (off < 24'd8) begin
                     asm_in = {asm_ff[55:0], data_byte};
                  end else if (off < 24'd12) begin
                     vend_in = {vend_ff[23:0], data_byte};
                  end
                  if (off == 24'd7) begin
                     // Vendor bit set: four more header bytes to come.
                     if (asm_in[31]) begin
                        if ({1'b0, start_ff} + 25'd12 > {1'b0, ml_ff}) begin
                           phase_in = dmp_pkg::PH_ERROR;
                           err_in   = dmp_pkg::ERR_AVP_OVERRUN;
                        end
                     end else begin
                        do_finish = 1'b1;
                     end
                  end else if (off == 24'd11) begin
                     do_finish = 1'b1;
                     hsz       = dmp_pkg::AVP_HDR_LONG;
                  end
               end
            end
            default: begin
            end
         endcase

         if (do_finish) begin
            avp_len = asm_in[23:0];
            if (avp_len < {20'd0, hsz}) begin
               phase_in = dmp_pkg::PH_ERROR;
               err_in   = dmp_pkg::ERR_AVP_SHORT;
            end else begin
               count_in = count_ff + 8'd1;
               mand_in  = mand_ff | mandatory_bit(asm_in[63:32]);
               entry.has_rec           = 1'b1;
               entry.rec.record_kind   = dmp_pkg::REC_AVP;
               entry.rec.code          = asm_in[63:32];
               entry.rec.flags         = asm_in[31:24];
               entry.rec.length        = avp_len;
               entry.rec.vendor_or_app = (hsz == dmp_pkg::AVP_HDR_LONG) ? vend_in : 32'd0;
               entry.rec.data_offset   = start_ff + {20'd0, hsz};
               entry.rec.data_length   = avp_len - {20'd0, hsz};
               entry.rec.avp_total     = count_in;
               // AVPs are padded to a four-byte boundary.
               next_avp = {2'b00, start_ff} +
                          (({2'b00, avp_len} + 26'd3) & ~26'd3);
               bgn = begin_avp(next_avp, ml_ff, count_in, avp_limit);
               phase_in = bgn.phase;
               err_in   = bgn.err;
               if (bgn.phase == dmp_pkg::PH_WALK) begin
                  start_in = bgn.start;
                  asm_in   = '0;
                  vend_in  = '0;
               end
            end
         end

         if (last_byte) begin
            if (new_pos < dmp_pkg::HDR_SIZE) begin
               fin_err = dmp_pkg::ERR_UNDER_HEADER;
            end else if (ml_in > new_pos) begin
               fin_err = dmp_pkg::ERR_BUFFER_SHORT;
            end else if (phase_in == dmp_pkg::PH_ERROR) begin
               fin_err = err_in;
            end
            entry.has_final           = 1'b1;
            entry.fin.record_kind     = (fin_err == dmp_pkg::ERR_NONE) ? dmp_pkg::REC_ACCEPT
                                                                       : dmp_pkg::REC_REJECT;
            entry.fin.avp_total       = count_in;
            entry.fin.error_kind      = fin_err;
            entry.fin.cer_valid       = (fin_err == dmp_pkg::ERR_NONE) &&
                                        (cmd_in[23:0] == dmp_pkg::CMD_CAPABILITIES) &&
                                        cmd_in[31] && (mand_in == dmp_pkg::MAND_ALL);
            // The next word starts a fresh message.
            phase_in = dmp_pkg::PH_HEADER;
            err_in   = dmp_pkg::ERR_NONE;
            pos_in   = '0;
            ml_in    = '0;
            cmd_in   = '0;
            app_in   = '0;
            hop_in   = '0;
            end_in   = '0;
            start_in = dmp_pkg::HDR_SIZE;
            asm_in   = '0;
            vend_in  = '0;
            count_in = '0;
            mand_in  = '0;
         end
      end
   end

   assign push = accept && (entry.has_rec || entry.has_final);

endmodule

/* sv/dmp_queue.sv */
// Short first-in first-out queue of parser entries between the front and back ends.
// Depends on dmp_pkg for the entry type.
module dmp_queue #(
   parameter int DEPTH = 4
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  dmp_pkg::entry_type push_data,
   input  logic               pop,
   output dmp_pkg::entry_type head,
   output logic               empty,
   output logic               full
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   dmp_pkg::entry_type mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   assign head  = mem_ff[rd_ptr_ff];
   assign empty = (count_ff == '0);
   assign full  = (count_ff == FULL_CNT);

   a_no_push_full: assert property (@(posedge clock) disable iff (reset) push |-> !full)
      else $error("queue written while full");
   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset) pop |-> !empty)
      else $error("queue read while empty");
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
                                   count_ff <= FULL_CNT)
      else $error("queue count beyond depth");
   a_count_step: assert property (@(posedge clock) disable iff (reset)
                                  (push && !pop) |=> (count_ff == $past(count_ff) + CNT_W'(1)))
      else $error("queue count did not follow a lone write");

endmodule

/* sv/dmp_back.sv */
// Parser back end: takes entries from the queue and delivers their records in order.
// Depends on dmp_pkg; holds the output register and a slot for a deferred final record.
module dmp_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                empty,
   input  dmp_pkg::entry_type  head,
   output logic                pop,
   input  logic                rsp_stall,
   output logic                rsp_valid,
   output dmp_pkg::record_type rsp_rec
);

   logic                valid_ff, valid_in;
   logic                pend_ff, pend_in;
   dmp_pkg::record_type rec_ff, rec_in;
   dmp_pkg::record_type pend_rec_ff, pend_rec_in;
   logic                load;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         pend_ff  <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         pend_ff  <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      rec_ff      <= rec_in;
      pend_rec_ff <= pend_rec_in;
   end

   assign load = !valid_ff || !rsp_stall;
   assign pop  = load && !pend_ff && !empty;

   always_comb begin
      valid_in    = valid_ff;
      pend_in     = pend_ff;
      rec_in      = rec_ff;
      pend_rec_in = pend_rec_ff;
      if (load) begin
         if (pend_ff) begin
            // A byte that closed a record and the message: the verdict goes second.
            valid_in = 1'b1;
            rec_in   = pend_rec_ff;
            pend_in  = 1'b0;
         end else if (!empty) begin
            valid_in = 1'b1;
            if (head.has_rec) begin
               rec_in      = head.rec;
               pend_in     = head.has_final;
               pend_rec_in = head.fin;
            end else begin
               rec_in = head.fin;
            end
         end else begin
            valid_in = 1'b0;
         end
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_rec   = rec_ff;

endmodule

/* sv/diameter_message_parser_core.sv */
// Diameter message parser, top level.
// The req_ channel takes one message word per cycle (one byte, with req_last_byte on the
// final byte of the received buffer); a word is taken when req_valid is high and req_stall
// low. The rsp_ channel gives records in order: a header record after byte 20, one record
// for each parsed AVP, and an accept or reject record on the last byte. A record is taken
// when rsp_valid is high and rsp_stall low. The csr_ channel writes the AVP limit; csr_ready
// is always high, and writes belong between messages.
// A record that a word completes is written into the queue at the edge that takes the word,
// then loaded into the output register, which presents it on rsp_. A word is taken every
// cycle while req_stall is low; the queue of QUEUE_DEPTH entries between the parser and the
// output register only fills while the receiver stalls or when a word yields two records
// (a header or AVP record and the verdict), which the output register sends in turn.
// req_stall rises when that queue is full, so a stalled receiver holds words back only
// after QUEUE_DEPTH record-bearing words have gathered behind the output register.
// Synchronous reset empties the queue and output register, clears all message state and
// returns the AVP limit to 50. While rsp_stall is high the record on rsp_ is held unchanged.
// Depends on dmp_pkg, dmp_front, dmp_queue and dmp_back.
module diameter_message_parser_core #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_last_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_record_kind,
   output logic [31:0] rsp_code,
   output logic [7:0]  rsp_flags,
   output logic [23:0] rsp_length,
   output logic [31:0] rsp_vendor_or_app,
   output logic [31:0] rsp_hop_id,
   output logic [31:0] rsp_end_id,
   output logic [23:0] rsp_data_offset,
   output logic [23:0] rsp_data_length,
   output logic [7:0]  rsp_avp_total,
   output logic        rsp_cer_valid,
   output logic [2:0]  rsp_error_kind,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_data
);

   logic [7:0]          limit_ff, limit_in;
   logic                accept;
   logic                push;
   logic                pop;
   logic                empty;
   logic                full;
   dmp_pkg::entry_type  entry;
   dmp_pkg::entry_type  head;
   dmp_pkg::record_type rec;

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= dmp_pkg::AVP_LIMIT_RESET;
      end else begin
         limit_ff <= limit_in;
      end
   end

   assign csr_ready = 1'b1;
   assign limit_in  = (csr_valid && csr_ready) ? csr_data : limit_ff;
   assign req_stall = full;
   assign accept    = req_valid && !req_stall;

   dmp_front u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .data_byte (req_data_byte),
      .last_byte (req_last_byte),
      .avp_limit (limit_ff),
      .push      (push),
      .entry     (entry)
   );

   dmp_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (entry),
      .pop       (pop),
      .head      (head),
      .empty     (empty),
      .full      (full)
   );

   dmp_back u_back (
      .clock     (clock),
      .reset     (reset),
      .empty     (empty),
      .head      (head),
      .pop       (pop),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_rec   (rec)
   );

   assign rsp_record_kind   = rec.record_kind;
   assign rsp_code          = rec.code;
   assign rsp_flags         = rec.flags;
   assign rsp_length        = rec.length;
   assign rsp_vendor_or_app = rec.vendor_or_app;
   assign rsp_hop_id        = rec.hop_id;
   assign rsp_end_id        = rec.end_id;
   assign rsp_data_offset   = rec.data_offset;
   assign rsp_data_length   = rec.data_length;
   assign rsp_avp_total     = rec.avp_total;
   assign rsp_cer_valid     = rec.cer_valid;
   assign rsp_error_kind    = rec.error_kind;

endmodule
